// ----- sv/msl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package msl_pkg;

    localparam int PHASE_BITS_DEF = 24;
    localparam int SINE_ADDR_BITS_DEF = 8;

    localparam int INC_W = 24;
    localparam int SHAPE_W = 2;
    localparam int DEPTH_W = 16;
    localparam int COUNT_W = 12;
    localparam int LFO_W = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int WAVE_W = 17;
    localparam int PROD_W = 34;
    localparam int ROM_W = 15;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_INCREMENT = 2'd0,
        REG_WAVE_SHAPE      = 2'd1,
        REG_DEPTH_GAIN      = 2'd2
    } msl_reg_t;

    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SAW      = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAVE,
        ST_MULT,
        ST_OUT
    } msl_state_t;

    typedef struct packed {
        logic accept;
        logic wave_en;
        logic mult_en;
        logic out_load;
    } msl_cmd_t;

    typedef struct packed {
        logic out_free;
    } msl_status_t;

    // Divides a Taylor term by (2n)(2n+1) for the sine table build.
    function automatic logic [63:0] taylor_div(input logic [63:0] t, input int n);
        logic [63:0] res;
        case (n)
            1: res = t / 64'd6;
            2: res = t / 64'd20;
            3: res = t / 64'd42;
            4: res = t / 64'd72;
            5: res = t / 64'd110;
            6: res = t / 64'd156;
            7: res = t / 64'd210;
            default: res = t;
        endcase
        return res;
    endfunction

    // Quarter-wave sine entry k in Q15, evaluated at elaboration only.
    function automatic logic [ROM_W-1:0] sine_q15(input int k, input int abits);
        logic [63:0] x;
        logic [63:0] t;
        logic signed [63:0] s;
        logic signed [63:0] q;
        int n;
        x = (HALF_PI_Q30 * 64'(k)) >> abits;
        t = x;
        s = signed'(x);
        for (n = 1; n <= 7; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = taylor_div(t, n);
            if (n[0]) begin
                s = s - signed'(t);
            end else begin
                s = s + signed'(t);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        q = (s + 64'sd16384) >>> 15;
        if (q > 64'sd32767) begin
            q = 64'sd32767;
        end
        return q[ROM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/msl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module msl_ctrl
    import msl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire msl_status_t status,
    output msl_cmd_t         cmd
);

    msl_state_t state_reg;
    msl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_WAVE;
                end
            end
            ST_WAVE: state_next = ST_MULT;
            ST_MULT: state_next = ST_OUT;
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.accept = s_valid;
            end
            ST_WAVE: cmd.wave_en = 1'b1;
            ST_MULT: cmd.mult_en = 1'b1;
            ST_OUT:  cmd.out_load = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/msl_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module msl_datapath
    import msl_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int SINE_TABLE_ADDR_BITS = SINE_ADDR_BITS_DEF
)
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire msl_cmd_t                   cmd,
    output msl_status_t                     status,
    input  wire logic [COUNT_W-1:0]         sample_count,
    input  wire logic [INC_W-1:0]           phase_increment,
    input  wire logic [SHAPE_W-1:0]         wave_shape,
    input  wire logic [DEPTH_W-1:0]         depth_gain,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [LFO_W-1:0]         m_lfo_value
);

    localparam int A = SINE_TABLE_ADDR_BITS;
    localparam int N = 1 << A;
    localparam int STEP_W = INC_W + COUNT_W;

    logic [ROM_W-1:0] sine_rom [0:N];

    for (genvar k = 0; k <= N; k++) begin : g_rom
        localparam logic [ROM_W-1:0] ENTRY = sine_q15(k, A);
        assign sine_rom[k] = ENTRY;
    end

    logic [PHASE_BITS-1:0]    phase_reg;
    logic [PHASE_BITS-1:0]    phase_next;
    logic signed [WAVE_W-1:0] wave_reg;
    logic signed [WAVE_W-1:0] wave_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic signed [LFO_W-1:0]  value_reg;
    logic signed [LFO_W-1:0]  value_next;

    logic [STEP_W-1:0]        step;
    logic [31:0]              f;
    logic [16:0]              u;
    logic signed [17:0]       tri_lo;
    logic signed [17:0]       tri_hi;
    logic [A-1:0]             idx;
    logic [A:0]               rom_addr;
    logic signed [WAVE_W-1:0] sine_v;
    logic signed [18:0]       scaled;

    assign step = STEP_W'(phase_increment) * STEP_W'(sample_count);
    assign phase_next = phase_reg + step[PHASE_BITS-1:0];

    assign f = 32'(phase_reg) << (32 - PHASE_BITS);
    assign u = f[31:15];
    assign tri_lo = signed'({2'b00, u[15:0]}) - 18'sd32768;
    assign tri_hi = 18'sd98304 - signed'({1'b0, u});
    assign idx = f[29 -: A];
    assign rom_addr = f[30] ? ((A+1)'(N) - {1'b0, idx}) : {1'b0, idx};
    assign sine_v = signed'({2'b00, sine_rom[rom_addr]});

    always_comb begin
        case (wave_shape)
            SHAPE_TRIANGLE: wave_next = u[16] ? tri_hi[WAVE_W-1:0] : tri_lo[WAVE_W-1:0];
            SHAPE_SAW:      wave_next = signed'({~f[31], ~f[31], f[30:16]});
            SHAPE_SQUARE:   wave_next = f[31] ? -17'sd32768 : 17'sd32768;
            default:        wave_next = f[31] ? -sine_v : sine_v;
        endcase
    end

    assign prod_next = wave_reg * signed'({1'b0, depth_gain}) + 34'sd16384;
    assign scaled = prod_reg[33:15];

    always_comb begin
        if (scaled > 19'sd32767) begin
            value_next = 16'sh7FFF;
        end else if (scaled < -19'sd32768) begin
            value_next = 16'sh8000;
        end else begin
            value_next = scaled[LFO_W-1:0];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                phase_reg <= phase_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wave_en) begin
            wave_reg <= wave_next;
        end
        if (cmd.mult_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load) begin
            value_reg <= value_next;
        end
    end

    assign status.out_free = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_lfo_value = value_reg;

endmodule

`default_nettype wire

// ----- sv/multi_shape_lfo.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                        Direction  Contents
// input    s_valid s_ready s_*          in         sample_count, samples in one block
// result   m_valid m_ready m_*          out        lfo_value, Q1.15 scaled waveform
// config   cfg_we cfg_idx cfg_wdata     in         increment, shape, depth registers
//
// From acceptance to the next acceptance, the phase is advanced at the accepting edge,
// then the waveform, the depth product and the saturated result are registered in
// turn by the shared datapath; the result load waits while a result is still pending.
// Reset clears the phase, the output valid and the config registers to their defaults.
// A waiting result lets one more item in; that item then holds in the last stage
// with the input closed until the waiting result is taken.

module multi_shape_lfo
    import msl_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int SINE_TABLE_ADDR_BITS = SINE_ADDR_BITS_DEF
)
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [COUNT_W-1:0]      s_sample_count,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [LFO_W-1:0]      m_lfo_value,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata
);

    logic [INC_W-1:0]   inc_reg;
    logic [SHAPE_W-1:0] shape_reg;
    logic [DEPTH_W-1:0] depth_reg;
    msl_cmd_t           cmd;
    msl_status_t        status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg   <= INC_W'(350);
            shape_reg <= SHAPE_SINE;
            depth_reg <= DEPTH_W'(32768);
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_PHASE_INCREMENT: inc_reg   <= cfg_wdata[INC_W-1:0];
                REG_WAVE_SHAPE:      shape_reg <= cfg_wdata[SHAPE_W-1:0];
                REG_DEPTH_GAIN:      depth_reg <= cfg_wdata[DEPTH_W-1:0];
                default:             inc_reg   <= inc_reg;
            endcase
        end
    end

    msl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    msl_datapath #(
        .PHASE_BITS           (PHASE_BITS),
        .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .sample_count    (s_sample_count),
        .phase_increment (inc_reg),
        .wave_shape      (shape_reg),
        .depth_gain      (depth_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lfo_value     (m_lfo_value)
    );

endmodule

`default_nettype wire

// ----- sv/msl_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module msl_checker
    import msl_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [LFO_W-1:0]      m_lfo_value
);

    // After reset no result is pending and the block can take an item.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state after reset is wrong");

    // An accepted item keeps the input closed for the following compute cycles.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready ##1 !s_ready)
        else $error("item taken while another is in progress");

    // A new result appears only together with the return to idle.
    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result loaded without releasing the input");

    // A waiting result holds its value.
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lfo_value))
        else $error("pending result changed");

endmodule

bind multi_shape_lfo msl_checker u_msl_checker (.*);

`default_nettype wire

// ----- tb/multi_shape_lfo_tb.sv -----
`timescale 1ns / 1ps

module multi_shape_lfo_tb;
    import msl_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 9;
    localparam int PH_W = PHASE_BITS_DEF;
    localparam int TAB_BITS = SINE_ADDR_BITS_DEF;
    localparam int TAB_N = 1 << TAB_BITS;
    localparam int TOTAL_BLOCKS = 1550;
    localparam int LONG_HOLD = 400;
    localparam int PRESSURE_PHASE = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic signed [LFO_W-1:0] LFO_MAX = 16'sh7FFF;
    localparam logic signed [LFO_W-1:0] LFO_MIN = 16'sh8000;
    localparam logic signed [LFO_W-1:0] LFO_ZERO = 16'sh0000;
    localparam logic [INC_W-1:0] INC_RESET = 24'd350;
    localparam logic [DEPTH_W-1:0] DEPTH_UNITY = 16'd32768;

    typedef enum logic {
        ROW_WRITE,
        ROW_BLOCK
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    data;
        logic [COUNT_W-1:0]       count;
        logic                     pinned;
        logic signed [LFO_W-1:0]  value;
    } stim_row_t;

    localparam int NUM_DIRECTED = 30;
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd0, 1'b1, LFO_ZERO},
        '{ROW_WRITE, REG_PHASE_INCREMENT, 24'h400000, 12'd0, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd1, 1'b1, LFO_MAX},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd2, 1'b1, -16'sd32767},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd1, 1'b1, LFO_ZERO},
        '{ROW_WRITE, REG_WAVE_SHAPE, 24'(SHAPE_SQUARE), 12'd0, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd0, 1'b1, LFO_MAX},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd2, 1'b1, LFO_MIN},
        '{ROW_WRITE, REG_DEPTH_GAIN, 24'h00FFFF, 12'd0, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd0, 1'b1, LFO_MIN},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd2, 1'b1, LFO_MAX},
        '{ROW_WRITE, REG_DEPTH_GAIN, 24'd0, 12'd0, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd1, 1'b1, LFO_ZERO},
        '{ROW_WRITE, REG_WAVE_SHAPE, 24'(SHAPE_SAW), 12'd0, 1'b0, LFO_ZERO},
        '{ROW_WRITE, REG_DEPTH_GAIN, 24'(DEPTH_UNITY), 12'd0, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd3, 1'b1, LFO_MIN},
        '{ROW_WRITE, REG_WAVE_SHAPE, 24'(SHAPE_TRIANGLE), 12'd0, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd2, 1'b1, LFO_MAX},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd2, 1'b1, LFO_MIN},
        '{ROW_WRITE, REG_UNUSED, 24'hFFFFFF, 12'd0, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd1, 1'b1, LFO_ZERO},
        '{ROW_WRITE, REG_PHASE_INCREMENT, 24'hFFFFFF, 12'd0, 1'b0, LFO_ZERO},
        '{ROW_WRITE, REG_WAVE_SHAPE, 24'(SHAPE_SINE), 12'd0, 1'b0, LFO_ZERO},
        '{ROW_WRITE, REG_DEPTH_GAIN, 24'd12345, 12'd0, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd4095, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'hAAA, 1'b0, LFO_ZERO},
        '{ROW_WRITE, REG_DEPTH_GAIN, 24'd40000, 12'd0, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'h555, 1'b0, LFO_ZERO},
        '{ROW_WRITE, REG_WAVE_SHAPE, 24'(SHAPE_SAW), 12'd0, 1'b0, LFO_ZERO},
        '{ROW_BLOCK, REG_UNUSED, 24'd0, 12'd4095, 1'b0, LFO_ZERO}
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [COUNT_W-1:0] s_sample_count = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [LFO_W-1:0] m_lfo_value;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic row_pinned = 1'b0;
    logic signed [LFO_W-1:0] row_value = '0;

    int sine_quarter [0:TAB_N];
    logic [PH_W-1:0] lfo_phase;
    logic [INC_W-1:0] lfo_inc;
    logic [SHAPE_W-1:0] lfo_shape;
    logic [DEPTH_W-1:0] lfo_depth;
    logic signed [LFO_W-1:0] lfo_expected [$];
    logic signed [LFO_W-1:0] lfo_next;
    logic signed [LFO_W-1:0] lfo_want;

    int fail_count = 0;
    int blocks_sent = 0;
    int cycle_count = 0;
    bit tx_gapless = 1'b0;
    bit rx_burst = 1'b0;
    bit press_req = 1'b0;

    multi_shape_lfo i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_count (s_sample_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lfo_value    (m_lfo_value),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Quarter-wave sine entry in Q15 from a Q30 Taylor series up to the 15th power.
    function automatic int quarter_sine(input int k);
        longint unsigned x;
        longint unsigned term;
        longint acc;
        longint q;
        x = (HALF_PI_Q30 * 64'(k)) >> TAB_BITS;
        term = x;
        acc = x;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'(4 * n * n + 2 * n);
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        q = (acc + 64'sd16384) >>> 15;
        if (q > 32767) begin
            q = 32767;
        end
        return int'(q);
    endfunction

    function automatic int shape_value(input logic [SHAPE_W-1:0] shp, input logic [31:0] frac);
        int u;
        int v;
        int idx;
        case (shp)
            SHAPE_TRIANGLE: begin
                u = int'(frac >> 15);
                return (u < 65536) ? (u - 32768) : (98304 - u);
            end
            SHAPE_SAW: begin
                return int'(frac >> 16) - 32768;
            end
            SHAPE_SQUARE: begin
                return frac[31] ? -32768 : 32768;
            end
            default: begin
                idx = int'(frac[29 -: TAB_BITS]);
                v = frac[30] ? sine_quarter[TAB_N - idx] : sine_quarter[idx];
                return frac[31] ? -v : v;
            end
        endcase
    endfunction

    // Advances the phase by one audio block and returns the scaled, saturated value.
    function automatic logic signed [LFO_W-1:0] lfo_advance(input logic [COUNT_W-1:0] count);
        logic [31:0] frac;
        longint prod;
        lfo_phase = PH_W'(64'(lfo_phase) + 64'(lfo_inc) * 64'(count));
        frac = 32'(lfo_phase) << (32 - PH_W);
        prod = longint'(shape_value(lfo_shape, frac)) * longint'(lfo_depth) + 64'sd16384;
        prod = prod >>> 15;
        if (prod > 32767) begin
            prod = 32767;
        end else if (prod < -32768) begin
            prod = -32768;
        end
        return LFO_W'(prod);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            lfo_phase = '0;
            lfo_inc = INC_RESET;
            lfo_shape = SHAPE_SINE;
            lfo_depth = DEPTH_UNITY;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_PHASE_INCREMENT: lfo_inc = cfg_wdata[INC_W-1:0];
                    REG_WAVE_SHAPE:      lfo_shape = cfg_wdata[SHAPE_W-1:0];
                    REG_DEPTH_GAIN:      lfo_depth = cfg_wdata[DEPTH_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                lfo_next = lfo_advance(s_sample_count);
                lfo_expected.push_back(row_pinned ? row_value : lfo_next);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (lfo_expected.size() == 0) begin
                $error("lfo_value: result with no item outstanding, actual %0d", m_lfo_value);
                fail_count++;
            end else begin
                lfo_want = lfo_expected.pop_front();
                if (m_lfo_value !== lfo_want) begin
                    $error("lfo_value mismatch: expected %0d, actual %0d", lfo_want,
                           m_lfo_value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multi_shape_lfo_tb failed");
            $finish;
        end
    end

    initial begin : rx_side
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                rx_burst = !rx_burst;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 13);
            if (press_req) begin
                press_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (lfo_expected.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_block(input logic [COUNT_W-1:0] count, input logic pinned,
                              input logic signed [LFO_W-1:0] value);
        int gap;
        gap = tx_gapless ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_count <= count;
        row_pinned <= pinned;
        row_value <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        blocks_sent++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_increment();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 24'hFFFFFF;
            2: return CFG_DATA_W'($urandom_range(1, 2000));
            3: return 24'h800000 + CFG_DATA_W'($urandom_range(0, 15)) - 24'd8;
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_depth();
        logic [DEPTH_W-1:0] depth;
        case ($urandom_range(0, 5))
            0: depth = '0;
            1: depth = DEPTH_UNITY;
            2: depth = 16'hFFFF;
            3: depth = DEPTH_W'($urandom_range(32769, 65535));
            default: depth = DEPTH_W'($urandom_range(0, 32768));
        endcase
        return {8'($urandom()), depth};
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return COUNT_W'($urandom_range(1, 64));
            default: return COUNT_W'($urandom());
        endcase
    endfunction

    initial begin : tx_side
        int batch;
        int phase_no;
        for (int k = 0; k <= TAB_N; k++) begin
            sine_quarter[k] = quarter_sine(k);
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_WRITE) begin
                write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            end else begin
                send_block(DIRECTED[r].count, DIRECTED[r].pinned, DIRECTED[r].value);
            end
        end

        phase_no = 0;
        while (blocks_sent < TOTAL_BLOCKS) begin
            phase_no++;
            write_reg(REG_PHASE_INCREMENT, pick_increment());
            write_reg(REG_WAVE_SHAPE, CFG_DATA_W'($urandom()));
            write_reg(REG_DEPTH_GAIN, pick_depth());
            tx_gapless = ($urandom_range(0, 3) == 0);
            batch = $urandom_range(20, 80);
            // The receiver stops for a long stretch while the sender keeps offering items without gaps.
            if (phase_no == PRESSURE_PHASE) begin
                tx_gapless = 1'b1;
                batch = 80;
                press_req = 1'b1;
            end
            repeat (batch) begin
                send_block(pick_count(), 1'b0, LFO_ZERO);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && lfo_expected.size() == 0) begin
            $display("multi_shape_lfo_tb passed");
        end else begin
            $display("multi_shape_lfo_tb failed");
        end
        $finish;
    end

endmodule
